[src/mrt_pkg.sv]
// Shared types and constants for the masked route table.
package mrt_pkg;

    localparam int ENTRIES = 16;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DEL    = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic        compare;   // register the per-cell hit
        logic        commit;    // apply the resolved command
        t_cmd        cmd;
        logic [63:0] new_prefix;
        logic [63:0] new_mask;
        logic [63:0] new_gateway;
        logic [63:0] new_id;
        logic [63:0] target_id;
        logic [63:0] lookup_address;
    } t_cell_ctl;

    // Priority and gateway passed from cell to cell along the row.
    typedef struct packed {
        logic        taken;
        logic [63:0] gateway;
    } t_chain;

endpackage

[src/masked_route_table.sv]
// Top level of the masked route table: command capture, cell row and result register.
//
// First-match masked route table of mrt_pkg::ENTRIES slots, one cell per slot.
// Command channel: an item is taken at a rising edge with start high and busy
// low. i_command picks add, delete, lookup or clear; the other input fields are
// used only by the command that needs them.
// Result channel: o_strobe is high for exactly one cycle with o_status,
// o_assigned_id and o_found_gateway. The receiver cannot stall; every result
// must be taken in the cycle it is shown.
// Steps: the item is taken, then each cell's hit is registered in parallel,
// then priority is resolved along the row, the table is updated and the result
// is registered along with the strobe. busy is high for one cycle after each
// accept, and a new item can be taken while the last one is being resolved.
// The priority pass is a ripple along the cell row (lowest slot wins).
// Reset (synchronous, active low) empties the table, zeroes the id counter and
// drops busy and the strobe; no clearing pass is needed.
// Clear empties the table and zeroes the id counter as reset does, and returns status 0.
module masked_route_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_new_prefix,
    input  logic [63:0] i_new_mask,
    input  logic [63:0] i_new_gateway,
    input  logic [63:0] i_target_id,
    input  logic [63:0] i_lookup_address,
    output logic        o_strobe,
    output logic        o_status,
    output logic [63:0] o_assigned_id,
    output logic [63:0] o_found_gateway
);

    // Control: compare phase and resolve phase flags.
    logic r_busy;
    logic r_resolve;

    // Captured item.
    mrt_pkg::t_cmd r_cmd;
    logic [63:0]   r_new_prefix;
    logic [63:0]   r_new_mask;
    logic [63:0]   r_new_gateway;
    logic [63:0]   r_target_id;
    logic [63:0]   r_lookup_address;

    // Route id counter; the next id is precomputed for the winning cell.
    logic [63:0] r_ctr;
    logic [63:0] n_ctr;

    // Result registers.
    logic        r_strobe;
    logic        r_status;
    logic [63:0] r_assigned_id;
    logic [63:0] r_found_gateway;

    logic                accept;
    mrt_pkg::t_cell_ctl  cell_ctl;
    mrt_pkg::t_chain     chain [mrt_pkg::ENTRIES+1];
    logic [mrt_pkg::ENTRIES-1:0] sel;
    logic                any_hit;

    assign accept = start && !r_busy;
    assign busy   = r_busy;
    assign n_ctr  = r_ctr + 64'd1;

    always_comb begin
        cell_ctl.compare        = r_busy;
        cell_ctl.commit         = r_resolve;
        cell_ctl.cmd            = r_cmd;
        cell_ctl.new_prefix     = r_new_prefix;
        cell_ctl.new_mask       = r_new_mask;
        cell_ctl.new_gateway    = r_new_gateway;
        cell_ctl.new_id         = n_ctr;
        cell_ctl.target_id      = r_target_id;
        cell_ctl.lookup_address = r_lookup_address;
    end

    // Head of the row: nothing taken yet.
    assign chain[0].taken   = 1'b0;
    assign chain[0].gateway = 64'd0;

    for (genvar g = 0; g < mrt_pkg::ENTRIES; g++) begin : g_cell
        mrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_sel   (sel[g])
        );
    end

    assign any_hit = chain[mrt_pkg::ENTRIES].taken;

    // Control state and counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_resolve <= 1'b0;
            r_strobe  <= 1'b0;
            r_ctr     <= 64'd0;
            r_cmd     <= mrt_pkg::CMD_CLEAR;
        end else begin
            r_busy    <= accept;
            r_resolve <= r_busy;
            r_strobe  <= r_resolve;
            if (accept) begin
                r_cmd <= mrt_pkg::t_cmd'(i_command);
            end
            if (r_resolve) begin
                if (r_cmd == mrt_pkg::CMD_CLEAR) begin
                    r_ctr <= 64'd0;
                end else if (r_cmd == mrt_pkg::CMD_ADD && any_hit) begin
                    r_ctr <= n_ctr;
                end
            end
        end
    end

    // Item payload capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_new_prefix     <= i_new_prefix;
            r_new_mask       <= i_new_mask;
            r_new_gateway    <= i_new_gateway;
            r_target_id      <= i_target_id;
            r_lookup_address <= i_lookup_address;
        end
    end

    // Result payload; unused fields are zero.
    always_ff @(posedge i_clk) begin
        if (r_resolve) begin
            r_status        <= !(any_hit || r_cmd == mrt_pkg::CMD_CLEAR);
            r_assigned_id   <= (r_cmd == mrt_pkg::CMD_ADD && any_hit) ? n_ctr : 64'd0;
            r_found_gateway <= (r_cmd == mrt_pkg::CMD_LOOKUP && any_hit)
                               ? chain[mrt_pkg::ENTRIES].gateway : 64'd0;
        end
    end

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_assigned_id   = r_assigned_id;
    assign o_found_gateway = r_found_gateway;

    // An accepted item is compared, then resolved and registered as a result,
    // and its strobe shows together with that result.
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##2 o_strobe)
        else $error("accepted item produced no result strobe");

    // busy covers only the compare cycle, never two in a row.
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy)
        else $error("busy held longer than one cycle");

    // At most one cell wins the row during resolve.
    a_single_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_resolve |-> $onehot0(sel))
        else $error("more than one cell selected");

    // A failing result carries zero fields.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status) |-> (o_assigned_id == 64'd0 && o_found_gateway == 64'd0))
        else $error("failure result with nonzero fields");

endmodule

[src/mrt_cell.sv]
// One route slot: holds an entry, compares it, and passes priority to its neighbor.
module mrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrt_pkg::t_cell_ctl i_ctl,
    input  mrt_pkg::t_chain    i_chain,
    output mrt_pkg::t_chain    o_chain,
    output logic               o_sel
);

    logic        r_valid;
    logic [63:0] r_id;
    logic [63:0] r_prefix;
    logic [63:0] r_mask;
    logic [63:0] r_gateway;
    logic        r_hit;
    logic        n_hit;

    always_comb begin
        case (i_ctl.cmd)
            mrt_pkg::CMD_ADD:    n_hit = !r_valid;
            mrt_pkg::CMD_DEL:    n_hit = r_valid && (r_id == i_ctl.target_id);
            mrt_pkg::CMD_LOOKUP: n_hit = r_valid &&
                                         ((i_ctl.lookup_address & r_mask) == r_prefix);
            default:             n_hit = 1'b0;
        endcase
    end

    // First hit in the row wins.
    assign o_sel           = r_hit && !i_chain.taken;
    assign o_chain.taken   = i_chain.taken || r_hit;
    assign o_chain.gateway = i_chain.gateway | (o_sel ? r_gateway : 64'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_id    <= 64'd0;
            r_hit   <= 1'b0;
        end else begin
            if (i_ctl.compare) begin
                r_hit <= n_hit;
            end
            if (i_ctl.commit) begin
                if (i_ctl.cmd == mrt_pkg::CMD_CLEAR) begin
                    r_valid <= 1'b0;
                    r_id    <= 64'd0;
                end else if (o_sel && i_ctl.cmd == mrt_pkg::CMD_ADD) begin
                    r_valid <= 1'b1;
                    r_id    <= i_ctl.new_id;
                end else if (o_sel && i_ctl.cmd == mrt_pkg::CMD_DEL) begin
                    r_valid <= 1'b0;
                    r_id    <= 64'd0;
                end
            end
        end
    end

    // Entry payload, written only by a winning add.
    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && o_sel && i_ctl.cmd == mrt_pkg::CMD_ADD) begin
            r_prefix  <= i_ctl.new_prefix;
            r_mask    <= i_ctl.new_mask;
            r_gateway <= i_ctl.new_gateway;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for masked_route_table: directed table, then random commands.
module tb;

    // Random items after the directed table; the tail of the run has no idling.
    localparam int RANDOM_ITEMS = 1800;
    localparam int QUIET_TAIL = 300;
    // Extra cycles to wait before the verdict once no result is outstanding.
    localparam int SETTLE_CYCLES = 8;

    // One command as presented on the input ports.
    typedef struct packed {
        mrt_pkg::t_cmd cmd;
        logic [63:0]   prefix;
        logic [63:0]   mask;
        logic [63:0]   gateway;
        logic [63:0]   target;
        logic [63:0]   address;
    } t_route_cmd;

    // One result as seen on the output ports.
    typedef struct packed {
        logic        status;
        logic [63:0] id;
        logic [63:0] gateway;
    } t_route_result;

    // Directed row: repeated reps times; typed rows carry the answer by hand.
    typedef struct packed {
        t_route_cmd    item;
        logic [4:0]    reps;
        logic          typed;
        t_route_result answer;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_command;
    logic [63:0] i_new_prefix;
    logic [63:0] i_new_mask;
    logic [63:0] i_new_gateway;
    logic [63:0] i_target_id;
    logic [63:0] i_lookup_address;
    logic        o_strobe;
    logic        o_status;
    logic [63:0] o_assigned_id;
    logic [63:0] o_found_gateway;

    // Shadow copy of the route table, updated in accept order.
    logic        tbl_live    [mrt_pkg::ENTRIES];
    logic [63:0] tbl_id      [mrt_pkg::ENTRIES];
    logic [63:0] tbl_prefix  [mrt_pkg::ENTRIES];
    logic [63:0] tbl_mask    [mrt_pkg::ENTRIES];
    logic [63:0] tbl_gateway [mrt_pkg::ENTRIES];
    logic [63:0] last_id;

    t_route_result pending_results[$];
    t_stim_row     stim_table[$];
    int            mismatch_count = 0;

    masked_route_table u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_new_prefix     (i_new_prefix),
        .i_new_mask       (i_new_mask),
        .i_new_gateway    (i_new_gateway),
        .i_target_id      (i_target_id),
        .i_lookup_address (i_lookup_address),
        .o_strobe         (o_strobe),
        .o_status         (o_status),
        .o_assigned_id    (o_assigned_id),
        .o_found_gateway  (o_found_gateway)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Empty table, counter back to zero: both reset and the clear command.
    function automatic void empty_table();
        for (int s = 0; s < mrt_pkg::ENTRIES; s++) begin
            tbl_live[s]    = 1'b0;
            tbl_id[s]      = '0;
            tbl_prefix[s]  = '0;
            tbl_mask[s]    = '0;
            tbl_gateway[s] = '0;
        end
        last_id = '0;
    endfunction

    // Expected result of one command; applies its effect to the shadow table.
    // Lowest slot wins for every search, matching the priority ripple.
    function automatic t_route_result predict_route_result(input t_route_cmd c);
        t_route_result r;
        logic          done;
        r = '{status: 1'b1, id: '0, gateway: '0};
        done = 1'b0;
        case (c.cmd)
            mrt_pkg::CMD_ADD: begin
                // Table full leaves the counter alone.
                for (int s = 0; s < mrt_pkg::ENTRIES && !done; s++) begin
                    if (!tbl_live[s]) begin
                        last_id        = last_id + 64'd1;
                        tbl_live[s]    = 1'b1;
                        tbl_id[s]      = last_id;
                        tbl_prefix[s]  = c.prefix;
                        tbl_mask[s]    = c.mask;
                        tbl_gateway[s] = c.gateway;
                        r.status       = 1'b0;
                        r.id           = last_id;
                        done           = 1'b1;
                    end
                end
            end
            mrt_pkg::CMD_DEL: begin
                for (int s = 0; s < mrt_pkg::ENTRIES && !done; s++) begin
                    if (tbl_live[s] && tbl_id[s] == c.target) begin
                        tbl_live[s] = 1'b0;
                        tbl_id[s]   = '0;
                        r.status    = 1'b0;
                        done        = 1'b1;
                    end
                end
            end
            mrt_pkg::CMD_LOOKUP: begin
                // Stored prefix is compared as is, never masked.
                for (int s = 0; s < mrt_pkg::ENTRIES && !done; s++) begin
                    if (tbl_live[s] && (c.address & tbl_mask[s]) == tbl_prefix[s]) begin
                        r.status  = 1'b0;
                        r.gateway = tbl_gateway[s];
                        done      = 1'b1;
                    end
                end
            end
            mrt_pkg::CMD_CLEAR: begin
                empty_table();
                r.status = 1'b0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // Random live slot, or -1 when the table is empty.
    function automatic int live_slot();
        int first;
        int idx;
        first = $urandom_range(0, mrt_pkg::ENTRIES - 1);
        for (int k = 0; k < mrt_pkg::ENTRIES; k++) begin
            idx = (first + k) % mrt_pkg::ENTRIES;
            if (tbl_live[idx])
                return idx;
        end
        return -1;
    endfunction

    // Mostly well-formed traffic: prefixes inside their masks, deletes of live ids,
    // lookups aimed at a live route. All fields start random so every bit toggles.
    function automatic t_route_cmd random_route_cmd(input int add_pct);
        t_route_cmd c;
        int         pick;
        int         s;
        int         width;
        c.cmd     = mrt_pkg::CMD_LOOKUP;
        c.prefix  = rand64();
        c.mask    = rand64();
        c.gateway = rand64();
        c.target  = rand64();
        c.address = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 1) begin
            c.cmd = mrt_pkg::CMD_CLEAR;
        end else if (pick < 1 + add_pct) begin
            c.cmd = mrt_pkg::CMD_ADD;
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    // Leading-ones mask; short ones overlap and stress priority.
                    width = $urandom_range(0, 64);
                    c.mask = (width == 0) ? 64'd0 : ~64'd0 << (64 - width);
                end
                2: c.mask = ~64'd0;
                default: c.mask = rand64() & rand64() & rand64();
            endcase
            if ($urandom_range(0, 4) != 0)
                c.prefix = c.prefix & c.mask;
        end else if (pick < 1 + add_pct + (99 - add_pct) / 2) begin
            c.cmd = mrt_pkg::CMD_DEL;
            s = live_slot();
            case ($urandom_range(0, 9))
                0: ;
                1, 2: c.target = 64'($urandom_range(0, 32'(last_id) + 2));
                default: begin
                    if (s >= 0)
                        c.target = tbl_id[s];
                end
            endcase
        end else begin
            s = live_slot();
            if (s >= 0 && $urandom_range(0, 9) < 7)
                c.address = tbl_prefix[s] | (c.address & ~tbl_mask[s]);
        end
        return c;
    endfunction

    task automatic add_row(input mrt_pkg::t_cmd cmd, input logic [63:0] prefix,
                           input logic [63:0] mask,
                           input logic [63:0] gateway, input logic [63:0] target,
                           input logic [63:0] address, input int reps, input logic typed,
                           input logic status, input logic [63:0] id,
                           input logic [63:0] found);
        t_stim_row row;
        row.item   = '{cmd: cmd, prefix: prefix, mask: mask, gateway: gateway,
                       target: target, address: address};
        row.reps   = 5'(reps);
        row.typed  = typed;
        row.answer = '{status: status, id: id, gateway: found};
        stim_table.push_back(row);
    endtask

    // Present one item and hold it until accepted; the expectation is logged at
    // the accepting edge. start is left high for a back-to-back follow-up.
    task automatic send_item(input t_route_cmd c, input logic typed,
                             input t_route_result answer);
        t_route_result r;
        start            <= 1'b1;
        i_command        <= c.cmd;
        i_new_prefix     <= c.prefix;
        i_new_mask       <= c.mask;
        i_new_gateway    <= c.gateway;
        i_target_id      <= c.target;
        i_lookup_address <= c.address;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        r = predict_route_result(c);
        pending_results.push_back(typed ? answer : r);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every outstanding result has shown up.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Result checker: outputs are sampled before the edge updates them.
    always @(posedge i_clk) begin
        t_route_result want;
        if (o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing outstanding", {63'd0, o_status}, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    flag_mismatch("status", {63'd0, o_status}, {63'd0, want.status});
                if (o_assigned_id !== want.id)
                    flag_mismatch("assigned_id", o_assigned_id, want.id);
                if (o_found_gateway !== want.gateway)
                    flag_mismatch("found_gateway", o_found_gateway, want.gateway);
            end
        end
    end

    initial begin
        int add_pct;
        int idle_pct;
        start            <= 1'b0;
        i_command        <= mrt_pkg::CMD_LOOKUP;
        i_new_prefix     <= '0;
        i_new_mask       <= '0;
        i_new_gateway    <= '0;
        i_target_id      <= '0;
        i_lookup_address <= '0;
        i_rst_n          <= 1'b0;
        empty_table();

        // Directed table. Typed answers are the obvious ones; the fill run of
        // fifteen adds is left to the predictor.
        // Empty table: lookup and delete both miss.
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, '0, 1, 1'b1, 1'b1, '0, '0);
        add_row(mrt_pkg::CMD_DEL, '0, '0, '0, '0, '0, 1, 1'b1, 1'b1, '0, '0);
        // Catch-all route in slot 0 gets id 1.
        add_row(mrt_pkg::CMD_ADD, '0, '0, '1, '0, '0, 1, 1'b1, 1'b0, 64'd1, '0);
        // Fill the rest with exact-match routes for all ones.
        add_row(mrt_pkg::CMD_ADD, '1, '1, 64'h1234, '0, '0, 15, 1'b0, 1'b0, '0, '0);
        // Table full: refused, counter stays at 16.
        add_row(mrt_pkg::CMD_ADD, '0, '0, '0, '0, '0, 1, 1'b1, 1'b1, '0, '0);
        // Lowest slot wins over the exact matches.
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, '1, 1, 1'b1, 1'b0, '0, '1);
        add_row(mrt_pkg::CMD_DEL, '0, '0, '0, 64'd1, '0, 1, 1'b1, 1'b0, '0, '0);
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, '1, 1, 1'b1, 1'b0, '0, 64'h1234);
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, '0, 1, 1'b1, 1'b1, '0, '0);
        // Refill the freed slot; id continues past the refused add.
        add_row(mrt_pkg::CMD_ADD, 64'hF0, 64'h0F, 64'd5, '0, '0, 1, 1'b1, 1'b0, 64'd17, '0);
        // Prefix outside its mask never matches.
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, 64'hFF, 1, 1'b1, 1'b1, '0, '0);
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, 64'hF0, 1, 1'b1, 1'b1, '0, '0);
        // Deleting an id that is gone, or never existed.
        add_row(mrt_pkg::CMD_DEL, '0, '0, '0, 64'd1, '0, 1, 1'b1, 1'b1, '0, '0);
        add_row(mrt_pkg::CMD_DEL, '0, '0, '0, '1, '0, 1, 1'b1, 1'b1, '0, '0);
        // Clear empties the table and restarts ids at 1.
        add_row(mrt_pkg::CMD_CLEAR, '1, '1, '1, '1, '1, 1, 1'b1, 1'b0, '0, '0);
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, '1, 1, 1'b1, 1'b1, '0, '0);
        add_row(mrt_pkg::CMD_ADD, '0, '0, '0, '0, '0, 1, 1'b1, 1'b0, 64'd1, '0);
        add_row(mrt_pkg::CMD_LOOKUP, '0, '0, '0, '0, 64'hA5A5_5A5A_C3C3_3C3C, 1, 1'b0, 1'b0,
                '0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_table[r]) begin
            repeat (stim_table[r].reps) begin
                if ($urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 9));
                send_item(stim_table[r].item, stim_table[r].typed, stim_table[r].answer);
            end
        end
        wait_drained();

        // Random part: each block of 100 picks a fill or drain bias and an idle
        // density, including blocks with no gaps at all.
        add_pct = 35;
        idle_pct = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: add_pct = 60;
                    1: add_pct = 35;
                    default: add_pct = 15;
                endcase
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            if (n >= RANDOM_ITEMS - QUIET_TAIL)
                idle_pct = 0;
            if (n % 400 == 399 && n < RANDOM_ITEMS - QUIET_TAIL)
                wait_drained();
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                idle_cycles($urandom_range(1, 9));
            send_item(random_route_cmd(add_pct), 1'b0, '0);
        end

        start <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog: roughly twenty times the slowest legal run.
    initial begin
        #(5_000_000);
        $display("tb: errors");
        $finish;
    end

endmodule

[filelist.f]
src/mrt_pkg.sv
src/mrt_cell.sv
src/masked_route_table.sv
tb/tb.sv
